### hw/rtl/ssac_pkg.sv
// ssac_pkg: shared types, codes and default sizes for the snooping cache tag store
// used by ssac_ctrl, ssac_datapath and snooping_set_assoc_cache_tags_top
// no dependencies

package ssac_pkg;

    // default geometry
    localparam int DEF_ADDR_BITS   = 32;
    localparam int DEF_OFFSET_BITS = 5;
    localparam int DEF_INDEX_BITS  = 7;
    localparam int DEF_WAYS        = 4;

    // fixed port widths
    localparam int ADDR_IN_W  = 32;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 2;
    localparam int OUT_WAY_W  = 2;
    localparam int OUT_SET_W  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STORE       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SNOOP_LOAD  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SNOOP_STORE = 2'd3;

    // coherence modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VI   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MSI  = 2'd2;

    // line state codes
    localparam logic [1:0] ST_INV = 2'd0;
    localparam logic [1:0] ST_VAL = 2'd1;
    localparam logic [1:0] ST_SHR = 2'd2;
    localparam logic [1:0] ST_MOD = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_COHERENCE_MODE = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/ssac_ctrl.sv
// ssac_ctrl: sequencer for the tag store (clear sweep, capture, lookup/update)
// depends on ssac_pkg for the command and status structs

module ssac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssac_pkg::status_t status,
    output ssac_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb begin
        s_ready        = (state_reg == S_IDLE);
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.capture    = (state_reg == S_IDLE) && s_valid;
        cmd.update     = (state_reg == S_LOOKUP) && status.out_free;
    end

endmodule

### hw/rtl/ssac_datapath.sv
// ssac_datapath: set row memory, request capture, hit/victim logic and result register
// depends on ssac_pkg for codes, widths and the command and status structs

module ssac_datapath #(
    parameter int ADDR_BITS   = ssac_pkg::DEF_ADDR_BITS,
    parameter int OFFSET_BITS = ssac_pkg::DEF_OFFSET_BITS,
    parameter int INDEX_BITS  = ssac_pkg::DEF_INDEX_BITS,
    parameter int WAYS        = ssac_pkg::DEF_WAYS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ssac_pkg::cmd_t                   cmd,
    output ssac_pkg::status_t                status,
    input  logic [ssac_pkg::MODE_W-1:0]      coherence_mode,
    input  logic [ssac_pkg::KIND_W-1:0]      s_kind,
    input  logic [ssac_pkg::ADDR_IN_W-1:0]   s_address,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic                             m_writeback,
    output logic                             m_upgrade,
    output logic [ssac_pkg::OUT_WAY_W-1:0]   m_way_used,
    output logic [ssac_pkg::OUT_SET_W-1:0]   m_set_used
);

    localparam int SETS     = 1 << INDEX_BITS;
    localparam int IDX_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_BITS = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
    localparam int TAG_W    = (TAG_BITS > 0) ? TAG_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
    localparam logic [WAY_W:0]   WAYS_C   = (WAY_W + 1)'(WAYS);
    localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SETS - 1);

    // one memory row holds a whole set plus its victim pointer
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tags;
        logic [WAYS-1:0][1:0]       states;
        logic [WAYS-1:0]            dirty;
        logic [WAY_W-1:0]           ptr;
    } row_t;

    row_t mem [0:SETS-1];

    logic [ADDR_BITS-1:0]          addr_in;
    logic [IDX_W-1:0]              set_in;
    logic [TAG_W-1:0]              tag_in;

    logic [ssac_pkg::KIND_W-1:0]   kind_reg;
    logic [TAG_W-1:0]              tag_reg;
    logic [IDX_W-1:0]              set_reg;
    row_t                          row_reg;
    logic [IDX_W-1:0]              clr_cnt_reg;

    logic                          m_valid_reg;
    logic                          hit_reg;
    logic                          wb_reg;
    logic                          upg_reg;
    logic [ssac_pkg::OUT_WAY_W-1:0] way_reg;
    logic [ssac_pkg::OUT_SET_W-1:0] set_out_reg;

    row_t                          row_next;
    logic                          hit_next;
    logic                          wb_next;
    logic                          upg_next;
    logic [WAY_W-1:0]              way_next;

    // address split
    assign addr_in = ADDR_BITS'(s_address);
    assign set_in  = IDX_W'((addr_in >> OFFSET_BITS) & ADDR_BITS'(SETS - 1));
    assign tag_in  = TAG_W'(addr_in >> (OFFSET_BITS + INDEX_BITS));

    // capture request and read its set row
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            tag_reg  <= tag_in;
            set_reg  <= set_in;
            row_reg  <= mem[set_in];
        end
    end

    // row write: clear sweep or lookup update
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            mem[clr_cnt_reg] <= '0;
        end else if (cmd.update) begin
            mem[set_reg] <= row_next;
        end
    end

    // clear sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // lookup, victim selection and snoop state changes
    always_comb begin
        logic             msi;
        logic             vi;
        logic             store;
        logic             local_req;
        logic [WAYS-1:0]  match;
        logic [WAYS-1:0]  usable;
        logic             found;
        logic [WAY_W-1:0] hw;
        logic [WAY_W-1:0] victim;

        msi       = (coherence_mode == ssac_pkg::MODE_MSI);
        vi        = (coherence_mode == ssac_pkg::MODE_VI);
        store     = (kind_reg == ssac_pkg::KIND_STORE);
        local_req = kind_reg inside {ssac_pkg::KIND_LOAD, ssac_pkg::KIND_STORE};

        for (int w = 0; w < WAYS; w++) begin
            match[w]  = (row_reg.tags[w] == tag_reg);
            usable[w] = match[w] && (msi ? (row_reg.states[w] != ssac_pkg::ST_INV)
                                         : (row_reg.states[w] == ssac_pkg::ST_VAL));
        end

        // lowest usable matching way
        found = 1'b0;
        hw    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (usable[w]) begin
                found = 1'b1;
                hw    = WAY_W'(w);
            end
        end

        victim = ({1'b0, row_reg.ptr} >= WAYS_C) ? '0 : row_reg.ptr;

        row_next = row_reg;
        hit_next = 1'b0;
        wb_next  = 1'b0;
        upg_next = 1'b0;
        way_next = '0;

        if (local_req) begin
            if (found) begin
                hit_next = 1'b1;
                way_next = hw;
                if (store) begin
                    row_next.dirty[hw] = 1'b1;
                    if (msi) begin
                        row_next.states[hw] = ssac_pkg::ST_MOD;
                    end
                end
                row_next.ptr = (hw == LAST_WAY) ? '0 : hw + 1'b1;
            end else begin
                wb_next = row_reg.dirty[victim] &&
                          (row_reg.states[victim] == (msi ? ssac_pkg::ST_MOD
                                                          : ssac_pkg::ST_VAL));
                row_next.tags[victim]  = tag_reg;
                row_next.dirty[victim] = store;
                if (msi) begin
                    row_next.states[victim] = store ? ssac_pkg::ST_MOD : ssac_pkg::ST_SHR;
                end else begin
                    row_next.states[victim] = ssac_pkg::ST_VAL;
                end
                way_next     = victim;
                row_next.ptr = (victim == LAST_WAY) ? '0 : victim + 1'b1;
            end
        end else if (msi) begin
            // every matching line reacts to the snoop
            for (int w = 0; w < WAYS; w++) begin
                if (usable[w]) begin
                    hit_next = 1'b1;
                    if (row_reg.states[w] == ssac_pkg::ST_MOD) begin
                        wb_next = 1'b1;
                    end
                    if (kind_reg == ssac_pkg::KIND_SNOOP_LOAD) begin
                        row_next.states[w] = ssac_pkg::ST_SHR;
                    end else begin
                        if (row_reg.states[w] == ssac_pkg::ST_SHR) begin
                            upg_next = 1'b1;
                        end
                        row_next.states[w] = ssac_pkg::ST_INV;
                    end
                end
            end
        end else begin
            // first valid match only; invalidated in valid-invalid mode
            hit_next = found;
            if (vi && found) begin
                wb_next             = row_reg.dirty[hw];
                row_next.states[hw] = ssac_pkg::ST_INV;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            hit_reg     <= hit_next;
            wb_reg      <= wb_next;
            upg_reg     <= upg_next;
            way_reg     <= ssac_pkg::OUT_WAY_W'(way_next);
            set_out_reg <= ssac_pkg::OUT_SET_W'(set_reg);
        end
    end

    // outputs and status
    assign m_valid           = m_valid_reg;
    assign m_hit             = hit_reg;
    assign m_writeback       = wb_reg;
    assign m_upgrade         = upg_reg;
    assign m_way_used        = way_reg;
    assign m_set_used        = set_out_reg;
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.clear_last = (clr_cnt_reg == LAST_SET);

endmodule

### hw/rtl/snooping_set_assoc_cache_tags_top.sv
// snooping_set_assoc_cache_tags_top: top level with the register port, controller and datapath
// depends on ssac_pkg, ssac_ctrl and ssac_datapath

// Tag and state store of a set-associative write-back cache with optional
// valid-invalid or MSI snooping. In the accept state (S_IDLE) a request reads
// the whole set row (tags, states, dirty bits, victim pointer) from the
// single-port set memory into a register; in S_LOOKUP the block evaluates the
// lookup and writes the row back while loading the result register, waiting
// there while m_ready holds an earlier result back. s_ready then returns, so a
// new request is taken only after the previous one has written its row back.
// After reset all 2**INDEX_BITS sets (128 by default) are swept clear, one set
// per cycle, before the first request is taken. coherence_mode sits at byte
// address 0 and should only be written while no request is in flight.

module snooping_set_assoc_cache_tags_top #(
    parameter int ADDR_BITS   = ssac_pkg::DEF_ADDR_BITS,
    parameter int OFFSET_BITS = ssac_pkg::DEF_OFFSET_BITS,
    parameter int INDEX_BITS  = ssac_pkg::DEF_INDEX_BITS,
    parameter int WAYS        = ssac_pkg::DEF_WAYS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssac_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ssac_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ssac_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ssac_pkg::KIND_W-1:0]        s_kind,
    input  logic [ssac_pkg::ADDR_IN_W-1:0]     s_address,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic                               m_writeback,
    output logic                               m_upgrade,
    output logic [ssac_pkg::OUT_WAY_W-1:0]     m_way_used,
    output logic [ssac_pkg::OUT_SET_W-1:0]     m_set_used
);

    ssac_pkg::cmd_t               cmd;
    ssac_pkg::status_t            status;
    logic [ssac_pkg::MODE_W-1:0]  mode_reg;
    logic                         cfg_wr;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ssac_pkg::MODE_NONE;
        end else if (cfg_wr && (paddr[2] == ssac_pkg::REG_COHERENCE_MODE)) begin
            mode_reg <= pwdata[ssac_pkg::MODE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ssac_pkg::REG_COHERENCE_MODE)
                    ? ssac_pkg::APB_DATA_W'(mode_reg) : '0;

    // controller
    ssac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    ssac_datapath #(
        .ADDR_BITS   (ADDR_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .WAYS        (WAYS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .coherence_mode (mode_reg),
        .s_kind         (s_kind),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_writeback    (m_writeback),
        .m_upgrade      (m_upgrade),
        .m_way_used     (m_way_used),
        .m_set_used     (m_set_used)
    );

    // an upgrade miss is only reported for a snoop that found the line
    a_upgrade_has_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_upgrade |-> m_hit)
        else $error("upgrade miss reported without hit");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while lookup pending");

    // reset leaves no result pending
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

### tb/snooping_set_assoc_cache_tags_top_tb.sv
// snooping_set_assoc_cache_tags_top_tb: self-checking testbench for the snooping cache tag store
// holds its own tag/state/victim predictor, request driver, result checker and apb writer
// depends on ssac_pkg and snooping_set_assoc_cache_tags_top
`timescale 1ns / 1ps

module snooping_set_assoc_cache_tags_top_tb;

    localparam int WAYS          = ssac_pkg::DEF_WAYS;
    localparam int SETS          = 1 << ssac_pkg::DEF_INDEX_BITS;
    localparam int LINES         = SETS * WAYS;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    // mode code the block leaves unused, behaves as no coherence
    localparam logic [ssac_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [ssac_pkg::APB_ADDR_W-1:0] ADDR_COHERENCE_MODE = 3'd0;

    typedef struct packed {
        logic                           hit;
        logic                           writeback;
        logic                           upgrade;
        logic [ssac_pkg::OUT_WAY_W-1:0] way_used;
        logic [ssac_pkg::OUT_SET_W-1:0] set_used;
    } lookup_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ssac_pkg::APB_ADDR_W-1:0] paddr;
    logic [ssac_pkg::APB_DATA_W-1:0] pwdata;
    logic [ssac_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_valid;
    logic                            s_ready;
    logic [ssac_pkg::KIND_W-1:0]     s_kind;
    logic [ssac_pkg::ADDR_IN_W-1:0]  s_address;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_hit;
    logic                            m_writeback;
    logic                            m_upgrade;
    logic [ssac_pkg::OUT_WAY_W-1:0]  m_way_used;
    logic [ssac_pkg::OUT_SET_W-1:0]  m_set_used;

    // predictor copy of the tag store
    logic [19:0]                 tag_mem [LINES];
    logic [1:0]                  state_mem [LINES];
    logic                        dirty_mem [LINES];
    logic [1:0]                  victim_ptr [SETS];
    logic [ssac_pkg::MODE_W-1:0] cur_mode;

    lookup_result_t expected_lookups [$];

    int  error_count;
    int  request_count;
    int  result_count;
    int  hit_count;
    int  writeback_count;
    int  upgrade_count;
    int  cycle_count;
    bit  no_idle;
    bit  hold_off_req;
    int  stall_left;

    // address pools for the random phases
    logic [6:0]  pool_sets [4];
    logic [19:0] pool_tags [6];

    snooping_set_assoc_cache_tags_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_writeback    (m_writeback),
        .m_upgrade      (m_upgrade),
        .m_way_used     (m_way_used),
        .m_set_used     (m_set_used)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run-length guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_lookups.size());
            $display("snooping_set_assoc_cache_tags_top verification failed");
            $finish;
        end
    end

    function automatic bit line_usable(input logic [1:0] st, input bit msi);
        return msi ? (st != ssac_pkg::ST_INV) : (st == ssac_pkg::ST_VAL);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] mk_addr(input logic [19:0] tag, input logic [6:0] set);
        return {tag, set, 5'($urandom_range(0, 31))};
    endfunction

    // tag store predictor: one lookup, state update, expected result
    function automatic lookup_result_t cache_access(
        input logic [ssac_pkg::KIND_W-1:0] kind,
        input logic [31:0]                 addr
    );
        lookup_result_t r;
        logic [6:0]  set;
        logic [19:0] tag;
        bit          msi;
        bit          found;
        int          base;
        int          w;
        int          l;
        int          i;
        r     = '0;
        set   = addr[11:5];
        tag   = addr[31:12];
        msi   = (cur_mode == ssac_pkg::MODE_MSI);
        base  = set * WAYS;
        found = 1'b0;
        w     = 0;
        r.set_used = set;
        if (kind inside {ssac_pkg::KIND_LOAD, ssac_pkg::KIND_STORE}) begin
            for (i = 0; i < WAYS; i++) begin
                if (!found && tag_mem[base+i] == tag && line_usable(state_mem[base+i], msi)) begin
                    found = 1'b1;
                    w = i;
                end
            end
            if (found) begin
                r.hit = 1'b1;
                r.way_used = w[1:0];
                if (kind == ssac_pkg::KIND_STORE) begin
                    dirty_mem[base+w] = 1'b1;
                    if (msi) state_mem[base+w] = ssac_pkg::ST_MOD;
                end
                victim_ptr[set] = 2'((w + 1) % WAYS);
            end else begin
                w = victim_ptr[set];
                l = base + w;
                if (dirty_mem[l] &&
                    state_mem[l] == (msi ? ssac_pkg::ST_MOD : ssac_pkg::ST_VAL))
                    r.writeback = 1'b1;
                tag_mem[l]   = tag;
                dirty_mem[l] = (kind == ssac_pkg::KIND_STORE);
                if (msi)
                    state_mem[l] = (kind == ssac_pkg::KIND_STORE) ? ssac_pkg::ST_MOD
                                                                 : ssac_pkg::ST_SHR;
                else
                    state_mem[l] = ssac_pkg::ST_VAL;
                r.way_used = w[1:0];
                victim_ptr[set] = 2'((w + 1) % WAYS);
            end
        end else if (msi) begin
            // every matching line reacts to the snoop
            for (i = 0; i < WAYS; i++) begin
                l = base + i;
                if (tag_mem[l] == tag && line_usable(state_mem[l], 1'b1)) begin
                    r.hit = 1'b1;
                    if (state_mem[l] == ssac_pkg::ST_MOD) r.writeback = 1'b1;
                    if (kind == ssac_pkg::KIND_SNOOP_LOAD) begin
                        state_mem[l] = ssac_pkg::ST_SHR;
                    end else begin
                        if (state_mem[l] == ssac_pkg::ST_SHR) r.upgrade = 1'b1;
                        state_mem[l] = ssac_pkg::ST_INV;
                    end
                end
            end
        end else begin
            // valid-invalid drops the first match, no coherence only reports
            for (i = 0; i < WAYS; i++) begin
                l = base + i;
                if (!found && tag_mem[l] == tag && line_usable(state_mem[l], 1'b0)) begin
                    r.hit = 1'b1;
                    if (cur_mode == ssac_pkg::MODE_VI) begin
                        if (dirty_mem[l]) r.writeback = 1'b1;
                        state_mem[l] = ssac_pkg::ST_INV;
                        found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // request driver, entered and left at a rising edge
    task automatic send_request(input logic [ssac_pkg::KIND_W-1:0] kind,
                                input logic [31:0] addr);
        int gap;
        gap = no_idle ? 0 : pick_gap(60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        expected_lookups.push_back(cache_access(kind, addr));
        request_count++;
    endtask

    // drop valid and let every result come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write of the mode register, then read it back
    task automatic write_mode(input logic [ssac_pkg::MODE_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_COHERENCE_MODE;
        pwdata  <= {30'($urandom()), mode};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        cur_mode = mode;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[ssac_pkg::MODE_W-1:0] !== mode) begin
            $display("%0t mode readback expected %0d actual %0d", $time, mode,
                     prdata[ssac_pkg::MODE_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic new_pool();
        int i;
        for (i = 0; i < 4; i++) pool_sets[i] = 7'($urandom_range(0, SETS - 1));
        for (i = 0; i < 6; i++) begin
            case ($urandom_range(0, 5))
                0: pool_tags[i] = 20'h00000;
                1: pool_tags[i] = 20'hfffff;
                default: pool_tags[i] = 20'($urandom());
            endcase
        end
    endtask

    // mostly pooled addresses so sets fill, hit and evict; the rest fully random
    task automatic send_random(input int count);
        int                          n;
        int                          k;
        logic [ssac_pkg::KIND_W-1:0] kind;
        logic [31:0]                 addr;
        for (n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            if (k < 3) kind = ssac_pkg::KIND_LOAD;
            else if (k < 6) kind = ssac_pkg::KIND_STORE;
            else if (k < 8) kind = ssac_pkg::KIND_SNOOP_LOAD;
            else kind = ssac_pkg::KIND_SNOOP_STORE;
            if ($urandom_range(0, 99) < 85)
                addr = mk_addr(pool_tags[$urandom_range(0, 5)], pool_sets[$urandom_range(0, 3)]);
            else
                addr = $urandom();
            send_request(kind, addr);
        end
    endtask

    // no coherence: fill, hit, snoop report, dirty eviction
    task automatic test_plain_mode();
        int i;
        write_mode(ssac_pkg::MODE_NONE);
        send_request(ssac_pkg::KIND_LOAD, 32'h0000_0000);
        send_request(ssac_pkg::KIND_LOAD, 32'h0000_0000);
        send_request(ssac_pkg::KIND_STORE, 32'h0000_0000);
        send_request(ssac_pkg::KIND_SNOOP_LOAD, 32'h0000_0000);
        send_request(ssac_pkg::KIND_LOAD, 32'hffff_ffff);
        send_request(ssac_pkg::KIND_STORE, 32'hffff_ffff);
        for (i = 1; i <= 4; i++) send_request(ssac_pkg::KIND_STORE, mk_addr(20'(i), 7'd1));
        send_request(ssac_pkg::KIND_LOAD, mk_addr(20'd5, 7'd1));
        wait_idle();
    endtask

    // valid-invalid: snoops drop dirty lines with writeback
    task automatic test_vi_mode();
        write_mode(ssac_pkg::MODE_VI);
        send_request(ssac_pkg::KIND_SNOOP_STORE, mk_addr(20'd2, 7'd1));
        send_request(ssac_pkg::KIND_SNOOP_LOAD, mk_addr(20'd3, 7'd1));
        wait_idle();
    endtask

    // msi: shared fill, modify, downgrade, upgrade miss, store hit on a later way
    task automatic test_msi_mode();
        write_mode(ssac_pkg::MODE_MSI);
        send_request(ssac_pkg::KIND_LOAD, mk_addr(20'd7, 7'd9));
        send_request(ssac_pkg::KIND_STORE, mk_addr(20'd7, 7'd9));
        send_request(ssac_pkg::KIND_SNOOP_LOAD, mk_addr(20'd7, 7'd9));
        send_request(ssac_pkg::KIND_SNOOP_STORE, mk_addr(20'd7, 7'd9));
        send_request(ssac_pkg::KIND_STORE, mk_addr(20'd8, 7'd9));
        send_request(ssac_pkg::KIND_SNOOP_STORE, mk_addr(20'd8, 7'd9));
        send_request(ssac_pkg::KIND_LOAD, mk_addr(20'd1, 7'd10));
        send_request(ssac_pkg::KIND_LOAD, mk_addr(20'd2, 7'd10));
        send_request(ssac_pkg::KIND_LOAD, mk_addr(20'd3, 7'd10));
        send_request(ssac_pkg::KIND_STORE, mk_addr(20'd3, 7'd10));
        send_request(ssac_pkg::KIND_SNOOP_STORE, mk_addr(20'd3, 7'd10));
        wait_idle();
    endtask

    // unused mode code acts like no coherence
    task automatic test_unused_mode();
        write_mode(MODE_UNUSED);
        send_request(ssac_pkg::KIND_SNOOP_STORE, 32'h0000_0000);
        wait_idle();
    endtask

    task automatic test_random_phase(input logic [ssac_pkg::MODE_W-1:0] mode, input int count);
        write_mode(mode);
        new_pool();
        send_random(count);
        wait_idle();
    endtask

    // back-to-back requests with no idling on either side
    task automatic test_steady_stream();
        write_mode(ssac_pkg::MODE_MSI);
        new_pool();
        no_idle = 1'b1;
        send_random(150);
        wait_idle();
        no_idle = 1'b0;
    endtask

    // receiver holds off long while requests keep coming, block must stall its input
    task automatic test_back_pressure();
        write_mode(ssac_pkg::MODE_VI);
        new_pool();
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        send_random(60);
        no_idle = 1'b0;
        wait_idle();
    endtask

    // result receiver with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            stall_left = pick_gap(0) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t %s expected %0h actual %0h", $time, name, exp, act);
            error_count++;
        end
    endtask

    // result checker against the oldest expectation
    always @(posedge aclk) begin
        lookup_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t unexpected result hit %0b set %0h", $time, m_hit, m_set_used);
                error_count++;
            end else begin
                exp = expected_lookups.pop_front();
                check_field("hit", exp.hit, m_hit);
                check_field("writeback", exp.writeback, m_writeback);
                check_field("upgrade", exp.upgrade, m_upgrade);
                check_field("way_used", exp.way_used, m_way_used);
                check_field("set_used", exp.set_used, m_set_used);
                result_count++;
                hit_count       += exp.hit;
                writeback_count += exp.writeback;
                upgrade_count   += exp.upgrade;
            end
        end
    end

    initial begin
        int i;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_kind       = ssac_pkg::KIND_LOAD;
        s_address    = '0;
        m_ready      = 1'b0;
        error_count  = 0;
        request_count = 0;
        result_count = 0;
        hit_count    = 0;
        writeback_count = 0;
        upgrade_count = 0;
        cycle_count  = 0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        stall_left   = 0;
        cur_mode     = ssac_pkg::MODE_NONE;
        for (i = 0; i < LINES; i++) begin
            tag_mem[i]   = '0;
            state_mem[i] = ssac_pkg::ST_INV;
            dirty_mem[i] = 1'b0;
        end
        for (i = 0; i < SETS; i++) victim_ptr[i] = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_plain_mode();
        test_vi_mode();
        test_msi_mode();
        test_unused_mode();
        test_random_phase(ssac_pkg::MODE_MSI, 350);
        test_random_phase(ssac_pkg::MODE_VI, 300);
        test_random_phase(ssac_pkg::MODE_NONE, 250);
        test_random_phase(MODE_UNUSED, 200);
        test_steady_stream();
        test_back_pressure();
        test_random_phase(ssac_pkg::MODE_MSI, 350);
        test_random_phase(ssac_pkg::MODE_VI, 200);

        $display("%0d requests, %0d results across none, vi, msi and the unused mode code",
                 request_count, result_count);
        $display("%0d hits, %0d writebacks, %0d upgrade misses, incl. long receiver hold-off",
                 hit_count, writeback_count, upgrade_count);
        if (error_count == 0) begin
            $display("snooping_set_assoc_cache_tags_top verification clean");
        end else begin
            $display("snooping_set_assoc_cache_tags_top verification failed");
        end
        $finish;
    end

endmodule
